@@ hw/rtl/kca_pkg.sv @@
// kca_pkg: shared widths, codes and color helpers for the keyframe color animator.
// No dependencies; used by the channel interfaces and by keyframe_color_animator.
package kca_pkg;

    localparam int ACTION_W = 2;
    localparam int POS_W    = 5;
    localparam int COLOR_W  = 6;
    localparam int STEP_W   = 16;
    localparam int REP_W    = 8;
    localparam int CH_W     = 8;
    localparam int CH_N     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = POS_W;

    localparam int KEYFRAMES_DEF = 32;
    localparam int TICK_BITS_DEF = 16;

    // slot lookup covers position + 1, which may reach 2**POS_W
    localparam int SLOT_N = 2 ** (POS_W + 1);

    localparam int unsigned LEVEL = 85;
    localparam logic [COLOR_W-1:0] RED_MASK   = 6'b110000;
    localparam logic [COLOR_W-1:0] GREEN_MASK = 6'b001100;
    localparam logic [COLOR_W-1:0] BLUE_MASK  = 6'b000011;

    localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_START = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_FIXED = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_LOOP_FIRST = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOOP_LAST  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FINAL_LAST = 2'd2;

    localparam logic [POS_W-1:0] LOOP_FIRST_RST = 5'd2;
    localparam logic [POS_W-1:0] LOOP_LAST_RST  = 5'd0;
    localparam logic [POS_W-1:0] FINAL_LAST_RST = 5'd0;

    // index 0 blue, 1 green, 2 red
    typedef logic [CH_N-1:0][CH_W-1:0] rgb_t;

    function automatic logic [CH_W-1:0] expand_channel(input logic [1:0] v);
        return CH_W'(32'(v) * LEVEL);
    endfunction

    function automatic rgb_t expand_color(input logic [COLOR_W-1:0] c);
        rgb_t rgb;
        logic [COLOR_W-1:0] r;
        logic [COLOR_W-1:0] g;
        logic [COLOR_W-1:0] b;
        r = c & RED_MASK;
        g = c & GREEN_MASK;
        b = c & BLUE_MASK;
        rgb[2] = expand_channel(r[5:4]);
        rgb[1] = expand_channel(g[3:2]);
        rgb[0] = expand_channel(b[1:0]);
        return rgb;
    endfunction

endpackage

@@ hw/rtl/kca_if.sv @@
// kca_if: valid/ready channels of the keyframe color animator (request,
// result and register write). Depends on kca_pkg.
interface kca_req_if;
    import kca_pkg::*;
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [POS_W-1:0]    key_index;
    logic [COLOR_W-1:0]  palette_code;
    logic [STEP_W-1:0]   step_ticks;
    logic [REP_W-1:0]    repeat_count;

    modport source (output valid, action, key_index, palette_code, step_ticks, repeat_count,
                    input ready);
    modport sink   (input valid, action, key_index, palette_code, step_ticks, repeat_count,
                    output ready);
endinterface

interface kca_rsp_if;
    import kca_pkg::*;
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            running;
    logic            finished;

    modport source (output valid, red, green, blue, running, finished, input ready);
    modport sink   (input valid, red, green, blue, running, finished, output ready);
endinterface

interface kca_cfg_if;
    import kca_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/keyframe_color_animator.sv @@
// keyframe_color_animator: RGB crossfade sequencer over a keyframe table.
// Depends on kca_pkg and the channels in kca_if.
//
// One request is handled at a time and each yields one result. Keyframe writes,
// fixed colors and ticks while stopped go straight to the result; starts and ticks
// reaching a zero-length keyframe first read the length memory, ticks ending the
// animation on the final keyframe the color memory. A tick within a segment blends,
// one entering a new segment reads its length first: the three channel blends run as
// six multiply-then-divide terms on one shared restoring divider (a multiply step and
// eight quotient steps per term) after single-port reads of the color and length
// memories. The result register lets the next request enter while a result waits; a
// second result then holds the block, and its input, until the receiver takes the first.
module keyframe_color_animator #(
    parameter int KEYFRAMES = kca_pkg::KEYFRAMES_DEF,
    parameter int TICK_BITS = kca_pkg::TICK_BITS_DEF
) (
    input logic    clk,
    input logic    rst_n,
    kca_cfg_if.sink cfg,
    kca_req_if.sink req,
    kca_rsp_if.source rsp
);
    import kca_pkg::*;

    localparam int AW = $clog2(KEYFRAMES);
    localparam int DW = TICK_BITS + CH_W;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_LEN_RD  = 4'd1;
    localparam logic [3:0] S_LEN_CHK = 4'd2;
    localparam logic [3:0] S_CA_RD   = 4'd3;
    localparam logic [3:0] S_CB_RD   = 4'd4;
    localparam logic [3:0] S_CB_GOT  = 4'd5;
    localparam logic [3:0] S_MUL     = 4'd6;
    localparam logic [3:0] S_DIV     = 4'd7;
    localparam logic [3:0] S_EMIT    = 4'd8;

    localparam logic [2:0] TERM_LAST = 3'd5;

    typedef logic [SLOT_N-1:0][AW-1:0] slot_tab_t;

    function automatic slot_tab_t build_slot_tab();
        slot_tab_t tab;
        for (int i = 0; i < SLOT_N; i++)
        begin
            tab[i] = AW'(i % KEYFRAMES);
        end
        return tab;
    endfunction

    localparam slot_tab_t SLOT_TAB = build_slot_tab();

    logic [COLOR_W-1:0]   color_mem [KEYFRAMES];
    logic [TICK_BITS-1:0] len_mem   [KEYFRAMES];

    logic [3:0]           state_reg;
    rgb_t                 shown_reg;
    logic [POS_W-1:0]     pos_reg;
    logic [TICK_BITS-1:0] tick_reg;
    logic [TICK_BITS-1:0] len_reg;
    logic [REP_W-1:0]     rep_reg;
    logic                 fin_reg;
    logic                 start_reg;
    logic                 final_reg;
    logic [POS_W-1:0]     loop_first_reg;
    logic [POS_W-1:0]     loop_last_reg;
    logic [POS_W-1:0]     final_last_reg;

    logic [COLOR_W-1:0]   ca_reg;
    logic [COLOR_W-1:0]   cb_reg;
    logic [DW-1:0]        rem_reg;
    logic [CH_W-1:0]      q_reg;
    logic [2:0]           term_reg;
    logic [2:0]           bit_reg;
    rgb_t                 res_reg;

    logic                 out_valid_reg;
    rgb_t                 out_rgb_reg;
    logic                 out_running_reg;
    logic                 out_finished_reg;

    logic [COLOR_W-1:0]   color_q;
    logic [TICK_BITS-1:0] len_q;

    logic                 req_fire;
    logic [AW-1:0]        pos_slot;
    logic [AW-1:0]        next_slot;
    logic [AW-1:0]        key_slot;
    logic [AW-1:0]        color_raddr;
    logic                 color_we;
    logic [AW-1:0]        color_waddr;
    logic [COLOR_W-1:0]   color_wdata;
    logic                 len_we;

    logic [1:0]           ch;
    logic [COLOR_W-1:0]   src_idx;
    logic [1:0]           src_bits;
    logic [CH_W-1:0]      src_level;
    logic [TICK_BITS-1:0] mult_op;
    logic [DW-1:0]        div_sh;
    logic                 take;
    logic [CH_W-1:0]      q_next;
    rgb_t                 res_next;
    logic                 out_free;

    assign req_fire  = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign out_free  = !out_valid_reg || rsp.ready;

    assign pos_slot  = SLOT_TAB[{1'b0, pos_reg}];
    assign next_slot = SLOT_TAB[{1'b0, pos_reg} + 6'd1];
    assign key_slot  = SLOT_TAB[{1'b0, req.key_index}];
    assign color_raddr = (state_reg == S_CA_RD) ? pos_slot : next_slot;

    assign color_we    = req_fire && (req.action == ACT_WRITE || req.action == ACT_FIXED);
    assign color_waddr = (req.action == ACT_WRITE) ? key_slot : '0;
    assign color_wdata = req.palette_code;
    assign len_we      = req_fire && (req.action == ACT_WRITE);

    always_ff @(posedge clk)
    begin
        if (color_we)
        begin
            color_mem[color_waddr] <= color_wdata;
        end
        color_q <= color_mem[color_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (len_we)
        begin
            len_mem[key_slot] <= TICK_BITS'(req.step_ticks);
        end
        len_q <= len_mem[pos_slot];
    end

    // blend term: even terms a*(L-t), odd terms b*t, then divided by L
    assign ch      = term_reg[2:1];
    assign src_idx = term_reg[0] ? cb_reg : ca_reg;
    assign mult_op = term_reg[0] ? tick_reg : (len_reg - tick_reg);

    always_comb
    begin
        unique case (ch)
            2'd0:    src_bits = src_idx[1:0];
            2'd1:    src_bits = src_idx[3:2];
            2'd2:    src_bits = src_idx[5:4];
            default: src_bits = 2'd0;
        endcase
    end

    assign src_level = expand_channel(src_bits);
    assign div_sh    = DW'(len_reg) << bit_reg;
    assign take      = (rem_reg >= div_sh);
    assign q_next    = {q_reg[CH_W-2:0], take};

    always_comb
    begin
        res_next = res_reg;
        unique case (ch)
            2'd0:    res_next[0] = res_reg[0] + q_next;
            2'd1:    res_next[1] = res_reg[1] + q_next;
            2'd2:    res_next[2] = res_reg[2] + q_next;
            default: res_next = res_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loop_first_reg <= LOOP_FIRST_RST;
            loop_last_reg  <= LOOP_LAST_RST;
            final_last_reg <= FINAL_LAST_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                REG_LOOP_FIRST: loop_first_reg <= cfg.data;
                REG_LOOP_LAST:  loop_last_reg  <= cfg.data;
                REG_FINAL_LAST: final_last_reg <= cfg.data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            shown_reg        <= '0;
            pos_reg          <= '0;
            tick_reg         <= '0;
            len_reg          <= '0;
            rep_reg          <= '0;
            fin_reg          <= 1'b0;
            start_reg        <= 1'b0;
            final_reg        <= 1'b0;
            ca_reg           <= '0;
            cb_reg           <= '0;
            rem_reg          <= '0;
            q_reg            <= '0;
            term_reg         <= '0;
            bit_reg          <= '0;
            res_reg          <= '0;
            out_valid_reg    <= 1'b0;
            out_rgb_reg      <= '0;
            out_running_reg  <= 1'b0;
            out_finished_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && rsp.ready && state_reg != S_EMIT)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_fire)
                    begin
                        fin_reg   <= 1'b0;
                        start_reg <= 1'b0;
                        final_reg <= 1'b0;
                        unique case (req.action)
                            ACT_TICK:
                            begin
                                priority if (len_reg == '0)
                                begin
                                    state_reg <= S_EMIT;
                                end
                                else if (tick_reg < len_reg)
                                begin
                                    tick_reg  <= tick_reg + 1'b1;
                                    state_reg <= S_CA_RD;
                                end
                                else if (rep_reg != REP_W'(1) && pos_reg == loop_last_reg)
                                begin
                                    if (rep_reg > REP_W'(1))
                                    begin
                                        rep_reg <= rep_reg - 1'b1;
                                    end
                                    pos_reg   <= loop_first_reg;
                                    tick_reg  <= '0;
                                    state_reg <= S_LEN_RD;
                                end
                                else if (rep_reg == REP_W'(1) && pos_reg == final_last_reg)
                                begin
                                    len_reg   <= '0;
                                    final_reg <= 1'b1;
                                    state_reg <= S_CB_RD;
                                end
                                else
                                begin
                                    pos_reg   <= pos_reg + 1'b1;
                                    tick_reg  <= '0;
                                    state_reg <= S_LEN_RD;
                                end
                            end
                            ACT_WRITE:
                            begin
                                state_reg <= S_EMIT;
                            end
                            ACT_START:
                            begin
                                pos_reg   <= '0;
                                tick_reg  <= '0;
                                rep_reg   <= req.repeat_count;
                                start_reg <= 1'b1;
                                state_reg <= S_LEN_RD;
                            end
                            ACT_FIXED:
                            begin
                                len_reg   <= '0;
                                shown_reg <= expand_color(req.palette_code);
                                state_reg <= S_EMIT;
                            end
                            default:
                            begin
                                state_reg <= S_EMIT;
                            end
                        endcase
                    end
                end
                S_LEN_RD:
                begin
                    state_reg <= S_LEN_CHK;
                end
                S_LEN_CHK:
                begin
                    len_reg <= len_q;
                    priority if (start_reg)
                    begin
                        state_reg <= S_EMIT;
                    end
                    else if (len_q == '0)
                    begin
                        fin_reg   <= 1'b1;
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        state_reg <= S_CA_RD;
                    end
                end
                S_CA_RD:
                begin
                    state_reg <= S_CB_RD;
                end
                S_CB_RD:
                begin
                    ca_reg    <= color_q;
                    state_reg <= S_CB_GOT;
                end
                S_CB_GOT:
                begin
                    if (final_reg)
                    begin
                        shown_reg <= expand_color(color_q);
                        fin_reg   <= 1'b1;
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        cb_reg    <= color_q;
                        term_reg  <= '0;
                        res_reg   <= '0;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    rem_reg   <= DW'(src_level) * DW'(mult_op);
                    q_reg     <= '0;
                    bit_reg   <= 3'd7;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (take)
                    begin
                        rem_reg <= rem_reg - div_sh;
                    end
                    q_reg <= q_next;
                    if (bit_reg == 3'd0)
                    begin
                        res_reg <= res_next;
                        if (term_reg == TERM_LAST)
                        begin
                            shown_reg <= res_next;
                            state_reg <= S_EMIT;
                        end
                        else
                        begin
                            term_reg  <= term_reg + 1'b1;
                            state_reg <= S_MUL;
                        end
                    end
                    else
                    begin
                        bit_reg <= bit_reg - 1'b1;
                    end
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg    <= 1'b1;
                        out_rgb_reg      <= shown_reg;
                        out_running_reg  <= (len_reg != '0);
                        out_finished_reg <= fin_reg;
                        state_reg        <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.red      = out_rgb_reg[2];
    assign rsp.green    = out_rgb_reg[1];
    assign rsp.blue     = out_rgb_reg[0];
    assign rsp.running  = out_running_reg;
    assign rsp.finished = out_finished_reg;

endmodule
